[src/b64te_pkg.sv]
package b64te_pkg;

   localparam int unsigned TABLE_REGS   = 8;
   localparam int unsigned REG_W        = 64;
   localparam int unsigned CHAR_W       = 8;
   localparam int unsigned GROUP_W      = 6;
   localparam int unsigned TABLE_DEPTH  = 64;
   localparam int unsigned CSR_INDEX_W  = $clog2(TABLE_REGS);
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned GROUP_CHARS_DEFAULT = 7;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   typedef logic [TABLE_REGS-1:0][REG_W-1:0] table_regs_type;
   typedef logic [TABLE_DEPTH-1:0][CHAR_W-1:0] table_entries_type;

   // One classified byte: the groups it completes and the spaces that follow them.
   typedef struct packed {
      logic [GROUP_W-1:0] idx1;
      logic               space1;
      logic               has2;
      logic [GROUP_W-1:0] idx2;
      logic               space2;
   } cmd_type;

endpackage

[src/b64te_front.sv]
module b64te_front #(
   parameter int unsigned GROUP_CHARS = b64te_pkg::GROUP_CHARS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [b64te_pkg::CHAR_W-1:0] data_byte,
   output b64te_pkg::cmd_type           cmd
);
   import b64te_pkg::*;

   localparam int unsigned CNT_W = $clog2(GROUP_CHARS + 1);

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [GROUP_W-1:0] leftover_ff, leftover_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [GROUP_W-1:0] idx1, idx2;
   logic               has2;
   logic [CNT_W-1:0]   c1, c2, count_mid;
   logic               sp1, sp2;

   always_comb begin
      idx2        = '0;
      has2        = 1'b0;
      case (phase_ff)
         PHASE_0: begin
            idx1        = data_byte[7:2];
            leftover_in = {data_byte[1:0], 4'b0000};
            phase_in    = PHASE_1;
         end
         PHASE_1: begin
            idx1        = leftover_ff | {2'b00, data_byte[7:4]};
            leftover_in = {data_byte[3:0], 2'b00};
            phase_in    = PHASE_2;
         end
         default: begin
            // third byte completes the fourth group as well
            idx1        = leftover_ff | {4'b0000, data_byte[7:6]};
            idx2        = data_byte[5:0];
            has2        = 1'b1;
            leftover_in = '0;
            phase_in    = PHASE_0;
         end
      endcase
   end

   always_comb begin
      c1        = count_ff + CNT_W'(1);
      sp1       = (c1 >= CNT_W'(GROUP_CHARS));
      count_mid = sp1 ? '0 : c1;
      c2        = count_mid + CNT_W'(1);
      sp2       = has2 && (c2 >= CNT_W'(GROUP_CHARS));
      count_in  = has2 ? (sp2 ? '0 : c2) : count_mid;
   end

   // drop the second space when it would be a fourth result
   assign cmd.idx1   = idx1;
   assign cmd.space1 = sp1;
   assign cmd.has2   = has2;
   assign cmd.idx2   = idx2;
   assign cmd.space2 = sp2 && !sp1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_0;
         leftover_ff <= '0;
         count_ff    <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
         count_ff    <= count_in;
      end
   end

endmodule

[src/b64te_queue.sv]
module b64te_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64te_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output b64te_pkg::cmd_type pop_data,
   output logic               empty
);
   import b64te_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/b64te_back.sv]
module b64te_back (
   input  logic                             clock,
   input  logic                             reset,
   input  b64te_pkg::table_regs_type        table_chars,
   input  b64te_pkg::cmd_type               cmd,
   input  logic                             cmd_empty,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [b64te_pkg::CHAR_W-1:0]     rsp_out_char,
   output logic                             rsp_last
);
   import b64te_pkg::*;

   typedef enum logic [1:0] {
      STEP_CHAR1  = 2'd0,
      STEP_SPACE1 = 2'd1,
      STEP_CHAR2  = 2'd2,
      STEP_SPACE2 = 2'd3
   } step_type;

   step_type            step_ff, step_in;
   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   rsp_char_ff, char_in;
   logic                rsp_last_ff, last_in;

   table_entries_type   entries;
   logic [GROUP_W-1:0]  sel;
   logic                emit;

   assign entries = table_chars;
   assign emit    = !cmd_empty && (!rsp_valid_ff || rsp_ready);
   assign sel     = (step_ff == STEP_CHAR2) ? cmd.idx2 : cmd.idx1;

   always_comb begin
      case (step_ff)
         STEP_CHAR1: begin
            char_in = entries[sel];
            last_in = !cmd.space1 && !cmd.has2;
            step_in = cmd.space1 ? STEP_SPACE1 : (cmd.has2 ? STEP_CHAR2 : STEP_CHAR1);
         end
         STEP_SPACE1: begin
            char_in = SPACE_CHAR;
            last_in = !cmd.has2;
            step_in = cmd.has2 ? STEP_CHAR2 : STEP_CHAR1;
         end
         STEP_CHAR2: begin
            char_in = entries[sel];
            last_in = !cmd.space2;
            step_in = cmd.space2 ? STEP_SPACE2 : STEP_CHAR1;
         end
         default: begin
            char_in = SPACE_CHAR;
            last_in = 1'b1;
            step_in = STEP_CHAR1;
         end
      endcase
   end

   // retire the queued item with its final character
   assign cmd_pop      = emit && last_in;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_CHAR1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            step_ff      <= step_in;
            rsp_valid_ff <= 1'b1;
            rsp_char_ff  <= char_in;
            rsp_last_ff  <= last_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

[src/base64_table_encoder.sv]
// A byte is classified into the two-entry queue, and its first character then goes through
// the single result register; a stalled receiver delays it. Throughput: one character per
// cycle on the result side while the receiver is ready, one to three characters per byte;
// the queue between classifier and emitter lets new bytes be taken while earlier ones are emitted, until it is full.
// Reset (synchronous): clears the character table, carried bits, phase, count and queue.
module base64_table_encoder #(
   parameter int unsigned GROUP_CHARS = b64te_pkg::GROUP_CHARS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [b64te_pkg::CHAR_W-1:0]      req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [b64te_pkg::CHAR_W-1:0]      rsp_out_char,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [b64te_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [b64te_pkg::REG_W-1:0]       csr_data
);
   import b64te_pkg::*;

   table_regs_type table_ff;
   cmd_type        front_cmd, head_cmd;
   logic           queue_full, queue_empty, queue_pop, req_accept;

   assign csr_ready  = 1'b1;
   assign req_ready  = !queue_full;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff <= '0;
      end else if (csr_valid) begin
         table_ff[csr_index] <= csr_data;
      end
   end

   b64te_front #(
      .GROUP_CHARS (GROUP_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .cmd       (front_cmd)
   );

   b64te_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (head_cmd),
      .empty     (queue_empty)
   );

   b64te_back u_back (
      .clock        (clock),
      .reset        (reset),
      .table_chars  (table_ff),
      .cmd          (head_cmd),
      .cmd_empty    (queue_empty),
      .cmd_pop      (queue_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

[bench/b64te_char_checker.sv]
`timescale 1ns / 100ps
module b64te_char_checker #(
   parameter int unsigned GROUP_CHARS = b64te_pkg::GROUP_CHARS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [b64te_pkg::CHAR_W-1:0]      req_data_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [b64te_pkg::CHAR_W-1:0]      rsp_out_char,
   input  logic                              rsp_last,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [b64te_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [b64te_pkg::REG_W-1:0]       csr_data,
   output int                                mismatches,
   output int                                outstanding
);
   import b64te_pkg::*;

   localparam int unsigned MAX_CHARS_PER_BYTE = 3;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_item_type;

   char_item_type      expected_chars[$];
   char_item_type      byte_chars[$];
   char_item_type      head;
   table_regs_type     table_mirror;
   logic [GROUP_W-1:0] carry_bits;
   logic [1:0]         carry_phase;
   int unsigned        since_space;

   task automatic report(input string what, input logic [CHAR_W-1:0] got,
                         input logic [CHAR_W-1:0] want);
      mismatches++;
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
   endtask

   function automatic logic [CHAR_W-1:0] lookup(input logic [GROUP_W-1:0] idx);
      return table_mirror[idx[5:3]][{idx[2:0], 3'b000} +: CHAR_W];
   endfunction

   // A byte never yields more than three characters: drop anything beyond.
   function automatic void add_char(input logic [CHAR_W-1:0] ch);
      if (byte_chars.size() < MAX_CHARS_PER_BYTE) begin
         byte_chars.push_back('{ch: ch, last: 1'b0});
      end
   endfunction

   function automatic void emit_group(input logic [GROUP_W-1:0] idx);
      add_char(lookup(idx));
      since_space++;
      if (since_space >= GROUP_CHARS) begin
         add_char(SPACE_CHAR);
         since_space = 0;
      end
   endfunction

   function automatic void encode_byte(input logic [CHAR_W-1:0] b);
      logic [1:0]         ph;
      logic [GROUP_W-1:0] grp;
      byte_chars.delete();
      ph = (carry_phase > 2'd2) ? 2'd2 : carry_phase;
      grp = GROUP_W'((b >> (2 + 2 * ph)) | carry_bits);
      emit_group(grp);
      // low bits of the byte move to the top of the next group
      carry_bits = GROUP_W'(b << (4 - 2 * ph));
      ph = ph + 2'd1;
      if (ph == 2'd3) begin
         emit_group(carry_bits);
         carry_bits = '0;
         ph = 2'd0;
      end
      carry_phase = ph;
      byte_chars[byte_chars.size() - 1].last = 1'b1;
      foreach (byte_chars[i]) expected_chars.push_back(byte_chars[i]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         table_mirror = '0;
         carry_bits   = '0;
         carry_phase  = 2'd0;
         since_space  = 0;
      end else begin
         if (csr_valid && csr_ready) table_mirror[csr_index] = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report("character with nothing expected", rsp_out_char, 'x);
            end else begin
               head = expected_chars.pop_front();
               if (rsp_out_char !== head.ch) report("out_char", rsp_out_char, head.ch);
               if (rsp_last !== head.last) begin
                  report("last", CHAR_W'(rsp_last), CHAR_W'(head.last));
               end
            end
         end
         if (req_valid && req_ready) encode_byte(req_data_byte);
      end
      outstanding <= expected_chars.size();
   end

endmodule

[bench/tb_base64_table_encoder.sv]
`timescale 1ns / 100ps
module tb_base64_table_encoder;
   import b64te_pkg::*;

   localparam int unsigned GROUP_CHARS = GROUP_CHARS_DEFAULT;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CHAR_W-1:0]      req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAR_W-1:0]      rsp_out_char;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]       csr_data = '0;

   int mismatches;
   int outstanding;
   int hold_left = 0;
   int calm_left = 0;
   int burst_left = 0;

   base64_table_encoder #(.GROUP_CHARS(GROUP_CHARS)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   b64te_char_checker #(.GROUP_CHARS(GROUP_CHARS)) char_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: short stalls mostly, a few long ones, and calm stretches with none.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (calm_left > 0) begin
         rsp_ready <= 1'b1;
         calm_left <= calm_left - 1;
      end else begin
         case ($urandom_range(0, 9))
            5, 6, 7: begin
               rsp_ready <= 1'b0;
               hold_left <= $urandom_range(0, 2);
            end
            8: begin
               rsp_ready <= 1'b0;
               hold_left <= $urandom_range(5, 20);
            end
            9: begin
               rsp_ready <= 1'b1;
               calm_left <= $urandom_range(30, 80);
            end
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         burst_left = $urandom_range(15, 40);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   // Hold valid and data until the item is taken; keep valid up when no gap follows.
   task automatic push_byte(input logic [CHAR_W-1:0] b);
      int gap;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic load_table(input table_regs_type t);
      for (int r = 0; r < TABLE_REGS; r++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INDEX_W'(r);
         csr_data  <= t[r];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      logic [CHAR_W-1:0] b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else b = CHAR_W'($urandom);
         push_byte(b);
      end
   endtask

   function automatic table_regs_type random_table();
      table_regs_type t;
      for (int r = 0; r < TABLE_REGS; r++) t[r] = {$urandom, $urandom};
      return t;
   endfunction

   initial begin
      table_regs_type    alphabet;
      string             letters;
      logic [CHAR_W-1:0] opening[$];
      letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      for (int k = 0; k < TABLE_DEPTH; k++) alphabet[k / 8][(k % 8) * 8 +: 8] = letters[k];
      // two bytes at the end leave a partial group carried into the next phase
      opening = '{8'h4D, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                  8'h80, 8'h01, 8'h7F, 8'hAA, 8'h55, 8'hC3, 8'hFC, 8'h0F, 8'h3F,
                  8'h10, 8'hE0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_table(alphabet);
      foreach (opening[i]) push_byte(opening[i]);
      settle();

      load_table('1);
      run_random(40);
      settle();

      load_table(random_table());
      run_random(50);
      settle();

      load_table('0);
      run_random(30);
      settle();

      load_table(random_table());
      run_random(30);
      settle();
      run_random(30);
      settle();

      load_table(alphabet);
      run_random(40);
      settle();

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
